// ===== src/ocbi_pkg.sv =====
// Package: shared constants, codes and state type of the opacity table interpolation unit.
`default_nettype none
package ocbi_pkg;
    localparam int GRID_ROWS_DEF = 58;
    localparam int GRID_COLS_DEF = 20;
    localparam int Q_W           = 24;
    localparam int LR_W          = 28;
    localparam logic signed [LR_W-1:0] Q_SIX = LR_W'(6 * 65536);
    localparam logic signed [Q_W-1:0]  Q_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0]  Q_MIN = 24'sh800000;

    localparam logic       ACT_WRITE = 1'b0;
    localparam logic       ACT_QUERY = 1'b1;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_LOW  = 2'd1;
    localparam logic [1:0] CLAMP_HIGH = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_TRD   = 12'b000000000010,
        S_TCMP  = 12'b000000000100,
        S_RRD   = 12'b000000001000,
        S_RCMP  = 12'b000000010000,
        S_FETCH = 12'b000000100000,
        S_FLAST = 12'b000001000000,
        S_MUL   = 12'b000010000000,
        S_DSET  = 12'b000100000000,
        S_DIV   = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } ocbi_state_t;
endpackage
`default_nettype wire

// ===== src/ocbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ocbi_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1160
) (
    input  wire                      aclk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  waddr,
    input  wire [WIDTH-1:0]          wdata,
    input  wire [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== src/opacity_table_bilinear_interp_unit.sv =====
// Top level: opacity grid store with clamped bilinear interpolation in log space.
// Write item: taken in idle, and the unit stays ready. Query: a T axis search (rows 1 to 57),
// an R axis search (columns 1 to 19), a fetch of eight cells, three interpolations (each a
// multiply, divider setup, 55-step divider and final add) and the output state, which can stall.
// One item at a time; the grid RAM read port and the bit-serial divider set the query time.
// Reset (aresetn low, synchronous) clears control state; grid contents are kept.
`default_nettype none
module opacity_table_bilinear_interp_unit
    import ocbi_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // row[5:0], column[10:6], entry_value[34:11], log_temp[58:35], log_density[82:59]
    input  wire [87:0]  s_tdata,
    // action[0]
    input  wire [0:0]   s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // log_opacity[23:0], temp_clamped[25:24], ratio_clamped[27:26]
    output logic [31:0] m_tdata
);
    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);
    localparam int DEPTH = GRID_ROWS * GRID_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] COLS_A = AW'(GRID_COLS);
    localparam logic [RW-1:0] LAST_R = RW'(GRID_ROWS - 1);
    localparam logic [CW-1:0] LAST_C = CW'(GRID_COLS - 1);
    localparam int NW = 55;   // divider numerator width
    localparam int DW = 25;   // divisor magnitude width

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
        cell_addr = AW'(AW'(r) * COLS_A) + AW'(c);
    endfunction

    // input fields
    logic [5:0]            in_row;
    logic [4:0]            in_col;
    logic signed [Q_W-1:0] in_entry, in_lt, in_ld;
    assign in_row   = s_tdata[5:0];
    assign in_col   = s_tdata[10:6];
    assign in_entry = s_tdata[34:11];
    assign in_lt    = s_tdata[58:35];
    assign in_ld    = s_tdata[82:59];

    ocbi_state_t state_reg;
    logic [RW-1:0] ti_reg;
    logic [CW-1:0] rj_reg;
    logic signed [Q_W-1:0]  lt_reg;
    logic signed [LR_W-1:0] lr_reg;
    logic [1:0] tflag_reg, rflag_reg;
    logic [2:0] k_reg;
    logic       cap_en_reg;
    logic [2:0] cap_idx_reg;
    logic signed [Q_W-1:0] val_reg [8];
    logic signed [Q_W-1:0] kmin_reg, kmax_reg;
    logic [1:0] l_reg;
    logic signed [53:0] prod_reg;
    logic signed [DW-1:0] den_reg;
    logic signed [Q_W-1:0] a0_reg;
    logic [NW-1:0] num_reg;
    logic [DW-1:0] ud_reg, rem_reg;
    logic neg_reg, dzero_reg;
    logic [5:0] dcnt_reg;
    logic signed [Q_W-1:0] res_reg;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic accept;
    logic wr_en;
    logic [AW-1:0] raddr;
    logic [Q_W-1:0] rd_raw;
    logic signed [Q_W-1:0] rd;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser[0] == ACT_WRITE) &&
                      (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
    assign rd       = $signed(rd_raw);

    ocbi_ram #(.WIDTH(Q_W), .DEPTH(DEPTH)) u_grid (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (cell_addr(RW'(in_row), CW'(in_col))),
        .wdata (in_entry),
        .raddr (raddr),
        .rdata (rd_raw)
    );

    // read address select
    always_comb begin
        raddr = '0;
        case (state_reg)
            S_TRD:   raddr = cell_addr(ti_reg, '0);
            S_RRD:   raddr = cell_addr('0, rj_reg);
            S_FETCH: begin
                case (k_reg)
                    3'd0:    raddr = cell_addr('0, rj_reg - 1'b1);
                    3'd1:    raddr = cell_addr('0, rj_reg);
                    3'd2:    raddr = cell_addr(ti_reg - 1'b1, rj_reg - 1'b1);
                    3'd3:    raddr = cell_addr(ti_reg - 1'b1, rj_reg);
                    3'd4:    raddr = cell_addr(ti_reg, rj_reg - 1'b1);
                    3'd5:    raddr = cell_addr(ti_reg, rj_reg);
                    3'd6:    raddr = cell_addr(ti_reg - 1'b1, '0);
                    default: raddr = cell_addr(ti_reg, '0);
                endcase
            end
            default: raddr = '0;
        endcase
    end

    // log R from the incoming query
    logic signed [LR_W-1:0] lt6, lr_in;
    assign lt6   = LR_W'(in_lt) - Q_SIX;
    assign lr_in = LR_W'(in_ld) - (lt6 + (lt6 <<< 1));

    // interpolation operand select
    logic signed [Q_W-1:0]  op_a0, op_a1, op_x0, op_x1;
    logic signed [LR_W-1:0] op_x;
    always_comb begin
        case (l_reg)
            2'd0: begin
                op_a0 = val_reg[2]; op_a1 = val_reg[3];
                op_x0 = val_reg[0]; op_x1 = val_reg[1]; op_x = lr_reg;
            end
            2'd1: begin
                op_a0 = val_reg[4]; op_a1 = val_reg[5];
                op_x0 = val_reg[0]; op_x1 = val_reg[1]; op_x = lr_reg;
            end
            default: begin
                op_a0 = kmin_reg; op_a1 = kmax_reg;
                op_x0 = val_reg[6]; op_x1 = val_reg[7]; op_x = LR_W'(lt_reg);
            end
        endcase
    end

    logic signed [DW-1:0] diff_a;
    logic signed [28:0]   diff_x;
    assign diff_a = DW'(op_a1) - DW'(op_a0);
    assign diff_x = 29'(op_x) - 29'(op_x0);

    // divider setup and step
    logic [53:0] prod_mag;
    logic [DW-1:0] den_mag;
    logic [DW:0] rem_sh;
    logic        qbit;
    assign prod_mag = prod_reg[53] ? 54'(-prod_reg) : 54'(prod_reg);
    assign den_mag  = den_reg[DW-1] ? DW'(-den_reg) : DW'(den_reg);
    assign rem_sh   = {rem_reg, num_reg[NW-1]};
    assign qbit     = (rem_sh >= {1'b0, ud_reg});

    // final add and saturate
    logic signed [56:0] sum;
    logic signed [Q_W-1:0] sat_sum;
    always_comb begin
        if (dzero_reg) begin
            sum = 57'(a0_reg);
        end else if (neg_reg) begin
            sum = 57'(a0_reg) - $signed({2'b00, num_reg});
        end else begin
            sum = 57'(a0_reg) + $signed({2'b00, num_reg});
        end
        if (sum > 57'(Q_MAX)) begin
            sat_sum = Q_MAX;
        end else if (sum < 57'(Q_MIN)) begin
            sat_sum = Q_MIN;
        end else begin
            sat_sum = Q_W'(sum);
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (accept && s_tuser[0] == ACT_QUERY) begin
                        lt_reg    <= in_lt;
                        lr_reg    <= lr_in;
                        ti_reg    <= RW'(1);
                        tflag_reg <= CLAMP_NONE;
                        rflag_reg <= CLAMP_NONE;
                        state_reg <= S_TRD;
                    end
                end
                S_TRD: state_reg <= S_TCMP;
                S_TCMP: begin
                    if (ti_reg < LAST_R && rd < lt_reg) begin
                        ti_reg    <= ti_reg + 1'b1;
                        state_reg <= S_TRD;
                    end else begin
                        if (ti_reg == RW'(1)) begin
                            if (lt_reg < rd) tflag_reg <= CLAMP_LOW;
                            lt_reg <= rd;
                            ti_reg <= RW'(2);
                        end else if (ti_reg == LAST_R && rd < lt_reg) begin
                            tflag_reg <= CLAMP_HIGH;
                            lt_reg    <= rd;
                        end
                        rj_reg    <= CW'(1);
                        state_reg <= S_RRD;
                    end
                end
                S_RRD: state_reg <= S_RCMP;
                S_RCMP: begin
                    if (rj_reg < LAST_C && LR_W'(rd) < lr_reg) begin
                        rj_reg    <= rj_reg + 1'b1;
                        state_reg <= S_RRD;
                    end else begin
                        if (rj_reg == CW'(1)) begin
                            if (lr_reg < LR_W'(rd)) rflag_reg <= CLAMP_LOW;
                            lr_reg <= LR_W'(rd);
                            rj_reg <= CW'(2);
                        end else if (rj_reg == LAST_C && LR_W'(rd) < lr_reg) begin
                            rflag_reg <= CLAMP_HIGH;
                            lr_reg    <= LR_W'(rd);
                        end
                        k_reg     <= '0;
                        state_reg <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 3'd7) state_reg <= S_FLAST;
                end
                S_FLAST: begin
                    l_reg     <= 2'd0;
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= diff_a * diff_x;
                    den_reg   <= DW'(op_x1) - DW'(op_x0);
                    a0_reg    <= op_a0;
                    state_reg <= S_DSET;
                end
                S_DSET: begin
                    num_reg   <= NW'(prod_mag) + NW'(den_mag >> 1);
                    ud_reg    <= den_mag;
                    rem_reg   <= '0;
                    neg_reg   <= prod_reg[53] != den_reg[DW-1];
                    dzero_reg <= (den_reg == '0);
                    dcnt_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    rem_reg  <= qbit ? DW'(rem_sh - {1'b0, ud_reg}) : DW'(rem_sh);
                    num_reg  <= {num_reg[NW-2:0], qbit};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == 6'(NW - 1)) state_reg <= S_FIN;
                end
                S_FIN: begin
                    case (l_reg)
                        2'd0:    kmin_reg <= sat_sum;
                        2'd1:    kmax_reg <= sat_sum;
                        default: res_reg  <= sat_sum;
                    endcase
                    if (l_reg == 2'd2) begin
                        state_reg <= S_OUT;
                    end else begin
                        l_reg     <= l_reg + 1'b1;
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // capture of fetched cells, in the cycle after each address is presented
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_en_reg <= 1'b0;
        end else begin
            cap_en_reg <= (state_reg == S_FETCH);
        end
        cap_idx_reg <= k_reg;
        if (cap_en_reg) val_reg[cap_idx_reg] <= rd;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {4'b0000, rflag_reg, tflag_reg, res_reg};
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && ud_reg != '0) |-> (rem_reg < ud_reg))
        else $error("divider remainder out of bound");
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown outside output state");
    a_pair_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FETCH) |-> (ti_reg >= RW'(2) && rj_reg >= CW'(2)))
        else $error("interpolation pair index below two");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser[0] == ACT_QUERY) |=> (state_reg == S_TRD))
        else $error("query not started");
endmodule
`default_nettype wire
